[sv/outstanding_instruction_fifo_hazard_core_defines.svh]
// assertion macros for the outstanding instruction tracker
`ifndef OUTSTANDING_INSTRUCTION_FIFO_HAZARD_CORE_DEFINES_SVH
`define OUTSTANDING_INSTRUCTION_FIFO_HAZARD_CORE_DEFINES_SVH

// checked outside reset
`define OIFH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define OIFH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/oifh_pkg.sv]
package oifh_pkg;

  localparam int DEPTH  = 4;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = 2;
  localparam int PC_W   = 32;
  localparam int REG_W  = 5;
  localparam int N_OPS  = 4;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [PC_W-1:0]  pc;
    logic [REG_W-1:0] idx;
    logic             df;
    logic             dw;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic             isf;
    logic [REG_W-1:0] idx;
  } operand_t;

  typedef struct packed {
    logic [N_OPS-1:0] hazard;
    entry_t           ret;
  } chain_t;

endpackage

[sv/oifh_cell.sv]
module oifh_cell (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     wr,
  input  logic                                     clr,
  input  oifh_pkg::entry_t                         wdata,
  input  oifh_pkg::operand_t [oifh_pkg::N_OPS-1:0] ops,
  input  oifh_pkg::chain_t                         chain_in,
  output oifh_pkg::chain_t                         chain_out
);

  oifh_pkg::entry_t          entry;
  oifh_pkg::entry_t          entry_wr;
  oifh_pkg::entry_t          entry_next;
  logic [oifh_pkg::N_OPS-1:0] hit;

  // a push lands before a pop of the same slot
  assign entry_wr   = wr ? wdata : entry;
  assign entry_next = clr ? '0 : entry_wr;

  always_comb begin
    for (int k = 0; k < oifh_pkg::N_OPS; k++) begin
      hit[k] = ops[k].en && (ops[k].idx != '0) && entry_next.dw &&
               (entry_next.df == ops[k].isf) && (entry_next.idx == ops[k].idx);
    end
  end

  assign chain_out.hazard = chain_in.hazard | hit;
  assign chain_out.ret    = chain_in.ret | (clr ? entry_wr : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

[sv/outstanding_instruction_fifo_hazard_core.sv]
// channel | handshake           | word
// in      | in_valid / in_stall   | dispatch/retire request and operand fields
// out     | out_valid / out_stall | slots, retired entry, ready, hazards, empty
//
// one word per cycle; a result appears in the output register the cycle after
// its word is taken, the slot cells updating and checking in that same cycle
// in_stall is high while a result is held under out_stall
// synchronous reset empties the tracker and drops any held result
module outstanding_instruction_fifo_hazard_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              dispatch_valid,
  input  logic                              retire_valid,
  input  logic [oifh_pkg::PC_W-1:0]         instr_pc,
  input  logic [oifh_pkg::REG_W-1:0]        dest_index,
  input  logic                              dest_is_float,
  input  logic                              dest_write,
  input  logic [2:0]                        source_enables,
  input  logic [2:0]                        source_float_flags,
  input  logic [oifh_pkg::REG_W-1:0]        src1_index,
  input  logic [oifh_pkg::REG_W-1:0]        src2_index,
  input  logic [oifh_pkg::REG_W-1:0]        src3_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [oifh_pkg::SLOT_W-1:0]       write_slot,
  output logic [oifh_pkg::SLOT_W-1:0]       read_slot,
  output logic                              retired,
  output logic [oifh_pkg::PC_W-1:0]         retired_pc,
  output logic [oifh_pkg::REG_W-1:0]        retired_dest_index,
  output logic                              retired_dest_write,
  output logic                              retired_dest_float,
  output logic                              dispatch_ready,
  output logic [oifh_pkg::N_OPS-1:0]        hazard_flags,
  output logic                              fifo_empty
);

  oifh_pkg::ptr_t wp;
  oifh_pkg::ptr_t rp;
  logic           full;
  logic           empty;

  oifh_pkg::ptr_t wp_next;
  oifh_pkg::ptr_t rp_next;
  logic           full_next;
  logic           empty_next;
  logic           accept;
  logic           push;
  logic           pop;
  logic           empty_mid;

  oifh_pkg::entry_t                         wdata;
  oifh_pkg::operand_t [oifh_pkg::N_OPS-1:0] ops;
  oifh_pkg::chain_t                         chain [oifh_pkg::DEPTH+1];

  function automatic oifh_pkg::ptr_t next_slot(oifh_pkg::ptr_t p);
    return (p == oifh_pkg::ptr_t'(oifh_pkg::DEPTH - 1)) ? '0 : p + oifh_pkg::ptr_t'(1);
  endfunction

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // full judged before the retire of the same word
  always_comb begin
    push       = accept && dispatch_valid && !full;
    wp_next    = push ? next_slot(wp) : wp;
    full_next  = push ? (wp_next == rp) : full;
    empty_mid  = push ? 1'b0 : empty;
    pop        = accept && retire_valid && !empty_mid;
    rp_next    = pop ? next_slot(rp) : rp;
    empty_next = pop ? (rp_next == wp_next) : empty_mid;
    if (pop) begin
      full_next = 1'b0;
    end
  end

  assign wdata = '{pc: instr_pc, idx: dest_index, df: dest_is_float, dw: dest_write};

  assign ops[0] = '{en: source_enables[0], isf: source_float_flags[0], idx: src1_index};
  assign ops[1] = '{en: source_enables[1], isf: source_float_flags[1], idx: src2_index};
  assign ops[2] = '{en: source_enables[2], isf: source_float_flags[2], idx: src3_index};
  assign ops[3] = '{en: dest_write, isf: dest_is_float, idx: dest_index};

  assign chain[0] = '0;

  for (genvar i = 0; i < oifh_pkg::DEPTH; i++) begin : g_cell
    oifh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr        (push && (wp == oifh_pkg::ptr_t'(i))),
      .clr       (pop && (rp == oifh_pkg::ptr_t'(i))),
      .wdata     (wdata),
      .ops       (ops),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      full      <= 1'b0;
      empty     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        wp    <= wp_next;
        rp    <= rp_next;
        full  <= full_next;
        empty <= empty_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      write_slot         <= oifh_pkg::SLOT_W'(wp);
      read_slot          <= oifh_pkg::SLOT_W'(rp);
      retired            <= pop;
      retired_pc         <= chain[oifh_pkg::DEPTH].ret.pc;
      retired_dest_index <= chain[oifh_pkg::DEPTH].ret.idx;
      retired_dest_write <= chain[oifh_pkg::DEPTH].ret.dw;
      retired_dest_float <= chain[oifh_pkg::DEPTH].ret.df;
      dispatch_ready     <= !full_next;
      hazard_flags       <= chain[oifh_pkg::DEPTH].hazard;
      fifo_empty         <= empty_next;
    end
  end

endmodule

[sv/oifh_checker.sv]
`include "outstanding_instruction_fifo_hazard_core_defines.svh"

module oifh_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              retired,
  input logic [oifh_pkg::PC_W-1:0]         retired_pc,
  input logic [oifh_pkg::REG_W-1:0]        retired_dest_index,
  input logic                              retired_dest_write,
  input logic                              retired_dest_float,
  input logic                              dispatch_ready,
  input logic                              fifo_empty
);

  logic ret_fields_set;

  assign ret_fields_set = |{retired_pc, retired_dest_index, retired_dest_write,
                            retired_dest_float};

  // held result stays up
  `OIFH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // never empty and full at once
  `OIFH_ASSERT(a_empty_full, out_valid |-> !(fifo_empty && !dispatch_ready), "empty and full")

  // no retire, no retired fields
  `OIFH_ASSERT(a_retired_zero, out_valid && !retired |-> !ret_fields_set, "retired fields set")

  // reset drops any held result
  `OIFH_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result shown after reset")

endmodule

bind outstanding_instruction_fifo_hazard_core oifh_checker u_oifh_checker (.*);
